@@ hw/rtl/i2cm_pkg.sv @@
// ============================================================================
// i2cm_pkg
// Shared types and constants for the I2C master bit engine.
// ============================================================================
`default_nettype none

package i2cm_pkg;

    // Queue depth between the front, the engine and the result port
    localparam int I2CM_QUEUE_DEPTH = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;
    localparam logic [9:0] ACK_TIMEOUT_RESET = 10'd250;

    // Raw opcodes on the input port
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_WAIT  = 3'd4;
    localparam logic [2:0] OP_READ  = 3'd5;

    // Classified command
    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_WAIT_ACK = 3'd4,
        CMD_READ     = 3'd5
    } t_cmd;

    // Bus phases
    localparam logic [4:0] PHASE_FIN   = 5'd31;
    localparam logic [4:0] PHASE_POLL  = 5'd2;
    localparam logic [4:0] PHASE_STOP0 = 5'd3;
    localparam logic [4:0] PHASE_ACKB  = 5'd16;

    localparam logic [4:0] NPH_START = 5'd2;
    localparam logic [4:0] NPH_STOP  = 5'd3;
    localparam logic [4:0] NPH_WRITE = 5'd16;
    localparam logic [4:0] NPH_WAIT  = 5'd6;
    localparam logic [4:0] NPH_READ  = 5'd18;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drv;
    } t_pins;

    localparam t_pins PINS_IDLE = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};

    // Item handed from the front to the engine
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_sample;
    } t_in_item;

    // One result per tick
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_received;
        logic       ack_timed_out;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/i2c_master_bit_engine_top.sv @@
// ============================================================================
// i2c_master_bit_engine_top
// I2C master bit engine: one bus tick per item, one result per tick.
// ============================================================================
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  tick in   | push / full          | i_opcode, i_data_byte, i_send_ack,
//            |                      | i_sda_sample
//  result    | empty / pop          | o_scl_level, o_sda_level, o_sda_drive,
//            |                      | o_busy_res, o_done_res, o_read_data,
//            |                      | o_ack_received, o_ack_timed_out
//  config    | i_cfg_we             | i_cfg_idx, i_cfg_data
//
//  One tick per clock sustained while the result queue is not full.
//  A transferred tick is held in the input queue, is stepped into the result
//  queue by the sequencer and can then be popped from there.
//  Synchronous reset empties both queues and returns the bus to idle.
//  full rises when the input queue holds DEPTH ticks; the sequencer halts
//  while the result queue is full and steps again on the cycle after a pop
//  frees a slot.
// ============================================================================
`default_nettype none

module i2c_master_bit_engine_top #(
    parameter int DEPTH = i2cm_pkg::I2CM_QUEUE_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [i2cm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // ticks
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [2:0]                       i_opcode,
    input  wire logic [7:0]                       i_data_byte,
    input  wire logic                             i_send_ack,
    input  wire logic                             i_sda_sample,
    // results
    output logic                                  empty,
    input  wire logic                             pop,
    output logic                                  o_scl_level,
    output logic                                  o_sda_level,
    output logic                                  o_sda_drive,
    output logic                                  o_busy_res,
    output logic                                  o_done_res,
    output logic [7:0]                            o_read_data,
    output logic                                  o_ack_received,
    output logic                                  o_ack_timed_out
);

    import i2cm_pkg::*;

    t_in_item item;
    t_result  res;
    logic     avail, take;

    i2cm_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_opcode     (i_opcode),
        .i_data_byte  (i_data_byte),
        .i_send_ack   (i_send_ack),
        .i_sda_sample (i_sda_sample),
        .o_avail      (avail),
        .i_take       (take),
        .o_item       (item)
    );

    i2cm_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_avail    (avail),
        .i_item     (item),
        .o_take     (take),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_res      (res)
    );

    assign o_scl_level     = res.scl_level;
    assign o_sda_level     = res.sda_level;
    assign o_sda_drive     = res.sda_drive;
    assign o_busy_res      = res.busy_res;
    assign o_done_res      = res.done_res;
    assign o_read_data     = res.read_data;
    assign o_ack_received  = res.ack_received;
    assign o_ack_timed_out = res.ack_timed_out;

endmodule

`default_nettype wire

@@ hw/rtl/i2cm_fifo.sv @@
// ============================================================================
// i2cm_fifo
// Small show-ahead queue used between the front, the engine and the port.
// ============================================================================
`default_nettype none

module i2cm_fifo #(
    parameter int DEPTH = i2cm_pkg::I2CM_QUEUE_DEPTH,
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/i2cm_front.sv @@
// ============================================================================
// i2cm_front
// Accepts ticks, classifies the opcode and queues the item for the engine.
// ============================================================================
`default_nettype none

module i2cm_front #(
    parameter int DEPTH = i2cm_pkg::I2CM_QUEUE_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    output logic                     o_full,
    input  wire logic [2:0]          i_opcode,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_send_ack,
    input  wire logic                i_sda_sample,
    output logic                     o_avail,
    input  wire logic                i_take,
    output i2cm_pkg::t_in_item       o_item
);

    import i2cm_pkg::*;

    t_in_item item_in;
    t_cmd     cmd;
    logic     q_empty;

    // opcode decode; unused codes are plain ticks
    always_comb begin
        case (i_opcode)
            OP_START: cmd = CMD_START;
            OP_STOP:  cmd = CMD_STOP;
            OP_WRITE: cmd = CMD_WRITE;
            OP_WAIT:  cmd = CMD_WAIT_ACK;
            OP_READ:  cmd = CMD_READ;
            default:  cmd = CMD_NONE;
        endcase
        item_in.cmd        = cmd;
        item_in.data_byte  = i_data_byte;
        item_in.send_ack   = i_send_ack;
        item_in.sda_sample = i_sda_sample;
    end

    i2cm_fifo #(
        .DEPTH (DEPTH),
        .WIDTH ($bits(t_in_item))
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (item_in),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_empty (q_empty),
        .o_data  (o_item)
    );

    assign o_avail = !q_empty;

endmodule

`default_nettype wire

@@ hw/rtl/i2cm_engine.sv @@
// ============================================================================
// i2cm_engine
// Bus sequencer: advances one tick per queued item and queues the result.
// ============================================================================
`default_nettype none

module i2cm_engine #(
    parameter int DEPTH = i2cm_pkg::I2CM_QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [i2cm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_avail,
    input  wire i2cm_pkg::t_in_item                 i_item,
    output logic                                    o_take,
    input  wire logic                               i_pop,
    output logic                                    o_empty,
    output i2cm_pkg::t_result                       o_res
);

    import i2cm_pkg::*;

    // SCL/SDA pattern of the stop sequence
    function automatic t_pins stop_pins(input logic [4:0] s);
        t_pins pv;
        pv.drv = 1'b1;
        pv.scl = (s != 5'd0);
        pv.sda = (s != 5'd0) && (s != 5'd1);
        return pv;
    endfunction

    function automatic logic [4:0] phase_limit(input t_cmd c);
        logic [4:0] n;
        case (c)
            CMD_START:    n = NPH_START;
            CMD_STOP:     n = NPH_STOP;
            CMD_WRITE:    n = NPH_WRITE;
            CMD_WAIT_ACK: n = NPH_WAIT;
            default:      n = NPH_READ;
        endcase
        return n;
    endfunction

    // pins shown from the first tick of phase p
    function automatic t_pins enter_pins(input t_cmd c, input logic [4:0] p,
                                         input logic [7:0] sh, input logic ackc,
                                         input logic tmo, input t_pins cur);
        t_pins pv;
        logic [2:0] bc;
        pv = cur;
        bc = p[3:1];
        if (p == PHASE_FIN) begin
            if (!(c == CMD_STOP || (c == CMD_WAIT_ACK && tmo))) begin
                pv.scl = 1'b0;
            end
        end else begin
            case (c)
                CMD_START: begin
                    pv = '{scl: 1'b1, sda: (p == 5'd0), drv: 1'b1};
                end
                CMD_STOP: begin
                    pv = stop_pins(p);
                end
                CMD_WRITE: begin
                    pv = '{scl: p[0], sda: sh[~bc], drv: 1'b1};
                end
                CMD_WAIT_ACK: begin
                    if (p >= PHASE_STOP0) begin
                        pv = stop_pins(p - PHASE_STOP0);
                    end else begin
                        pv = '{scl: (p != 5'd0), sda: 1'b1, drv: 1'b0};
                    end
                end
                CMD_READ: begin
                    if (p < PHASE_ACKB) begin
                        pv = '{scl: p[0], sda: 1'b1, drv: 1'b0};
                    end else begin
                        pv = '{scl: p[0], sda: !ackc, drv: 1'b1};
                    end
                end
                default: pv = cur;
            endcase
        end
        return pv;
    endfunction

    // configuration and sequencer state
    logic [7:0] r_half;
    logic [9:0] r_poll_lim;
    t_cmd       r_cmd,       n_cmd;
    logic [4:0] r_phase,     n_phase;
    logic [7:0] r_shift,     n_shift;
    logic [7:0] r_tick,      n_tick;
    logic [9:0] r_poll,      n_poll;
    logic       r_ack_choice, n_ack_choice;
    t_pins      r_pins,      n_pins;
    logic [7:0] r_read,      n_read;
    logic       r_ack_rx,    n_ack_rx;
    logic       r_ack_tmo,   n_ack_tmo;

    logic       step, out_full;
    logic [7:0] half_eff;
    logic [8:0] tick_inc;
    logic [4:0] next_ph;
    t_pins      shown;
    logic       done;
    t_result    res;

    assign step     = i_avail && !out_full;
    assign o_take   = step;
    assign half_eff = (r_half == 8'd0) ? 8'd1 : r_half;

    // one tick of the sequencer
    always_comb begin
        n_cmd        = r_cmd;
        n_phase      = r_phase;
        n_shift      = r_shift;
        n_tick       = r_tick;
        n_poll       = r_poll;
        n_ack_choice = r_ack_choice;
        n_pins       = r_pins;
        n_read       = r_read;
        n_ack_rx     = r_ack_rx;
        n_ack_tmo    = r_ack_tmo;
        done         = 1'b0;
        tick_inc     = '0;
        next_ph      = '0;

        // command launch while idle
        if (r_cmd == CMD_NONE && i_item.cmd != CMD_NONE) begin
            n_cmd  = i_item.cmd;
            n_poll = '0;
            if (i_item.cmd == CMD_WRITE) begin
                n_shift = i_item.data_byte;
            end
            if (i_item.cmd == CMD_READ) begin
                n_shift      = '0;
                n_ack_choice = i_item.send_ack;
            end
            if (i_item.cmd == CMD_WAIT_ACK) begin
                n_ack_rx  = 1'b0;
                n_ack_tmo = 1'b0;
            end
            n_phase = '0;
            n_tick  = '0;
            n_pins  = enter_pins(n_cmd, 5'd0, n_shift, n_ack_choice, n_ack_tmo, r_pins);
        end
        shown = n_pins;

        // phase advance
        if (n_cmd != CMD_NONE) begin
            if (n_phase == PHASE_FIN) begin
                if (n_cmd == CMD_READ) begin
                    n_read = n_shift;
                end
                done    = 1'b1;
                n_cmd   = CMD_NONE;
                n_phase = '0;
            end else if (n_cmd == CMD_WAIT_ACK && n_phase == PHASE_POLL) begin
                if (!i_item.sda_sample) begin
                    n_ack_rx = 1'b1;
                    n_phase  = PHASE_FIN;
                    n_tick   = '0;
                    n_pins   = enter_pins(n_cmd, PHASE_FIN, n_shift, n_ack_choice,
                                          n_ack_tmo, n_pins);
                end else if (n_poll >= r_poll_lim) begin
                    n_ack_tmo = 1'b1;
                    n_phase   = PHASE_STOP0;
                    n_tick    = '0;
                    n_pins    = enter_pins(n_cmd, PHASE_STOP0, n_shift, n_ack_choice,
                                           n_ack_tmo, n_pins);
                end else begin
                    n_poll = n_poll + 10'd1;
                end
            end else begin
                tick_inc = {1'b0, n_tick} + 9'd1;
                n_tick   = tick_inc[7:0];
                if (tick_inc >= {1'b0, half_eff}) begin
                    // read samples on the last tick of each high phase
                    if (n_cmd == CMD_READ && n_phase < PHASE_ACKB && n_phase[0]) begin
                        n_shift = {n_shift[6:0], i_item.sda_sample};
                    end
                    next_ph = n_phase + 5'd1;
                    n_phase = (next_ph >= phase_limit(n_cmd)) ? PHASE_FIN : next_ph;
                    n_tick  = '0;
                    n_pins  = enter_pins(n_cmd, n_phase, n_shift, n_ack_choice,
                                         n_ack_tmo, n_pins);
                end
            end
        end

        res.scl_level     = shown.scl;
        res.sda_level     = shown.sda;
        res.sda_drive     = shown.drv;
        res.busy_res      = (n_cmd != CMD_NONE);
        res.done_res      = done;
        res.read_data     = n_read;
        res.ack_received  = n_ack_rx;
        res.ack_timed_out = n_ack_tmo;
    end

    // state registers and configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half       <= HALF_PERIOD_RESET;
            r_poll_lim   <= ACK_TIMEOUT_RESET;
            r_cmd        <= CMD_NONE;
            r_phase      <= '0;
            r_shift      <= '0;
            r_tick       <= '0;
            r_poll       <= '0;
            r_ack_choice <= 1'b0;
            r_pins       <= PINS_IDLE;
            r_read       <= '0;
            r_ack_rx     <= 1'b0;
            r_ack_tmo    <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_HALF_PERIOD) begin
                r_half <= i_cfg_data[7:0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_ACK_TIMEOUT) begin
                r_poll_lim <= i_cfg_data[9:0];
            end
            if (step) begin
                r_cmd        <= n_cmd;
                r_phase      <= n_phase;
                r_shift      <= n_shift;
                r_tick       <= n_tick;
                r_poll       <= n_poll;
                r_ack_choice <= n_ack_choice;
                r_pins       <= n_pins;
                r_read       <= n_read;
                r_ack_rx     <= n_ack_rx;
                r_ack_tmo    <= n_ack_tmo;
            end
        end
    end

    // result queue toward the port
    i2cm_fifo #(
        .DEPTH (DEPTH),
        .WIDTH ($bits(t_result))
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_res)
    );

endmodule

`default_nettype wire

@@ hw/rtl/i2cm_checker.sv @@
// ============================================================================
// i2cm_checker
// Port-level checks for the I2C master bit engine, bound to the top level.
// ============================================================================
`default_nettype none

module i2cm_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             full,
    input  wire logic                             empty,
    input  wire logic                             pop,
    input  wire logic                             o_scl_level,
    input  wire logic                             o_sda_level,
    input  wire logic                             o_sda_drive,
    input  wire logic                             o_busy_res,
    input  wire logic                             o_done_res,
    input  wire logic [7:0]                       o_read_data,
    input  wire logic                             o_ack_received,
    input  wire logic                             o_ack_timed_out
);

    // reset leaves both queues empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_scl_level) && $stable(o_sda_level)
                              && $stable(o_sda_drive) && $stable(o_busy_res)
                              && $stable(o_done_res) && $stable(o_read_data)
                              && $stable(o_ack_received) && $stable(o_ack_timed_out)))
        else $error("stalled result changed");

    // the finish tick always ends the command
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_done_res) |-> !o_busy_res)
        else $error("done with command still busy");

    // an ACK wait ends one way only
    a_ack_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_ack_received && o_ack_timed_out))
        else $error("ACK both received and timed out");

endmodule

bind i2c_master_bit_engine_top i2cm_checker u_i2cm_checker (.*);

`default_nettype wire
